// ----- hdl/lss_pkg.sv -----
// lottery slot selector: shared types, codes and defaults
`timescale 1ns / 1ps

package lss_pkg;

	// default sizes for the top-level parameters
	localparam int SLOTS_DEF       = 8;
	localparam int TICKET_BITS_DEF = 16;

	// fixed field widths of the request and response words
	localparam int OPCODE_W  = 2;
	localparam int SLOT_W    = 3;
	localparam int TICKETS_W = 16;
	localparam int RANDOM_W  = 32;
	localparam int STATUS_W  = 3;
	localparam int LIVE_W    = 4;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_FINISH = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_DRAW   = 2'd2;

	// response status codes
	localparam logic [STATUS_W-1:0] STAT_ACK    = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_DRAWN  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_SINGLE = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_NONE   = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_ZERO   = 3'd4;

	// request word
	typedef struct packed {
		logic [OPCODE_W-1:0]  opcode;
		logic [SLOT_W-1:0]    slot;
		logic [TICKETS_W-1:0] tickets;
		logic [RANDOM_W-1:0]  random_value;
	} lss_req_t;

	// response word
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   chosen_slot;
		logic [LIVE_W-1:0]   live_count;
	} lss_rsp_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SUM,
		S_CHECK,
		S_DIV,
		S_PICK,
		S_REPLY
	} lss_state_t;

endpackage

// ----- hdl/lss_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module lss_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/lss_mod_unit.sv -----
// restoring remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps

module lss_mod_unit #(
	parameter int DIVIDEND_W = 32,
	parameter int DIVISOR_W  = 19
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVISOR_W-1:0]  remainder
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] dq_q;
	logic [DIVISOR_W-1:0]  dv_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    rem_next;

	// shift in the next dividend bit and subtract when it fits
	always_comb begin
		trial = {rem_q, dq_q[DIVIDEND_W-1]};
		if (trial >= {1'b0, dv_q}) begin
			rem_next = trial - {1'b0, dv_q};
		end else begin
			rem_next = trial;
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			dv_q  <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dq_q  <= dq_q << 1;
			rem_q <= rem_next[DIVISOR_W-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ----- hdl/lottery_slot_selector.sv -----
// lottery slot selector: top level with slot state, scan sequencer and reply register
//
//  channel | valid     | stall     | word
//  --------+-----------+-----------+------------------------------
//  request | req_valid | req_stall | req (opcode, slot, tickets, random_value)
//  reply   | rsp_valid | rsp_stall | rsp (status, chosen_slot, live_count)
//
// one item at a time: load, finish and unused opcodes pass through the decode and reply
// states before their reply is loaded, and the next request is then taken back in idle
// a draw makes two passes over the ticket ram (one slot read per cycle) around a
// 32-step remainder unit; shorter when no or one slot is live, when the pool is empty
// or when the pick lands early
// reset clears the live flags, live count, last winner and the reply valid
// req_stall is high from accept until the reply is loaded; a stalled reply holds its word
// and the next request can be taken while it waits

`timescale 1ns / 1ps

module lottery_slot_selector #(
	parameter int SLOTS       = lss_pkg::SLOTS_DEF,
	parameter int TICKET_BITS = lss_pkg::TICKET_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  lss_pkg::lss_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output lss_pkg::lss_rsp_t rsp
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int TOT_W = TICKET_BITS + IDX_W;

	lss_pkg::lss_state_t state_q, state_d;

	lss_pkg::lss_req_t                req_q;
	lss_pkg::lss_rsp_t                rsp_q;
	logic                             rsp_valid_q;
	logic [SLOTS-1:0]                 live_q;
	logic [lss_pkg::LIVE_W-1:0]       live_cnt_q;
	logic [lss_pkg::SLOT_W-1:0]       last_winner_q;
	logic                             win_vld_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic [IDX_W-1:0]                 idx_s1;
	logic [IDX_W-1:0]                 single_q;
	logic [TOT_W-1:0]                 run_q;
	logic [TOT_W-1:0]                 pick_q;
	logic [lss_pkg::STATUS_W-1:0]     res_status_q;
	logic [lss_pkg::SLOT_W-1:0]       res_chosen_q;

	// control strobes from the sequencer
	logic                         do_load;
	logic                         do_finish;
	logic                         scan_clr;
	logic                         scan_step;
	logic                         res_set;
	logic [lss_pkg::STATUS_W-1:0] res_status_d;
	logic [lss_pkg::SLOT_W-1:0]   res_chosen_d;
	logic                         win_set;
	logic                         div_start;
	logic                         rsp_load;

	// datapath signals
	logic [IDX_W-1:0]       slot_idx;
	logic                   slot_ok;
	logic                   live_at_slot;
	logic [TICKET_BITS-1:0] tk_s1;
	logic                   proc_vld;
	logic                   elig_s1;
	logic [TOT_W-1:0]       run_sum;
	logic                   hit;
	logic                   div_done;
	logic [TOT_W-1:0]       div_rem;

	// slot decode for load and finish
	assign slot_idx     = IDX_W'(req_q.slot);
	assign slot_ok      = 32'(req_q.slot) < SLOTS;
	assign live_at_slot = live_q[slot_idx];

	// ticket ram, read once per cycle at the scan counter
	lss_ram #(
		.WIDTH (TICKET_BITS),
		.DEPTH (SLOTS)
	) u_tickets (
		.clk   (clk),
		.we    (do_load),
		.waddr (slot_idx),
		.wdata (TICKET_BITS'(req_q.tickets)),
		.raddr (cnt_q[IDX_W-1:0]),
		.rdata (tk_s1)
	);

	// eligibility and the shared running-sum adder
	assign proc_vld = cnt_q != '0;
	assign elig_s1  = live_q[idx_s1] &&
		!(win_vld_q && (32'(idx_s1) == 32'(last_winner_q)));
	assign run_sum  = run_q + TOT_W'(tk_s1);
	assign hit      = proc_vld && elig_s1 && (pick_q < run_sum);

	// remainder of the random word by the eligible ticket total
	lss_mod_unit #(
		.DIVIDEND_W (lss_pkg::RANDOM_W),
		.DIVISOR_W  (TOT_W)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (req_q.random_value),
		.divisor   (run_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lss_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control strobes
	always_comb begin
		state_d      = state_q;
		req_stall    = 1'b1;
		do_load      = 1'b0;
		do_finish    = 1'b0;
		scan_clr     = 1'b0;
		scan_step    = 1'b0;
		res_set      = 1'b0;
		res_status_d = lss_pkg::STAT_ACK;
		res_chosen_d = '0;
		win_set      = 1'b0;
		div_start    = 1'b0;
		rsp_load     = 1'b0;
		unique case (state_q)
			lss_pkg::S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = lss_pkg::S_DECODE;
				end
			end
			lss_pkg::S_DECODE: begin
				res_set = 1'b1;
				state_d = lss_pkg::S_REPLY;
				unique case (req_q.opcode)
					lss_pkg::OP_LOAD: begin
						do_load = slot_ok;
					end
					lss_pkg::OP_FINISH: begin
						do_finish = slot_ok;
					end
					lss_pkg::OP_DRAW: begin
						if (live_cnt_q == '0) begin
							res_status_d = lss_pkg::STAT_NONE;
						end else begin
							scan_clr = 1'b1;
							state_d  = lss_pkg::S_SUM;
						end
					end
					default: begin
					end
				endcase
			end
			lss_pkg::S_SUM: begin
				scan_step = 1'b1;
				if (cnt_q == CNT_W'(SLOTS)) begin
					state_d = lss_pkg::S_CHECK;
				end
			end
			lss_pkg::S_CHECK: begin
				if (live_cnt_q == lss_pkg::LIVE_W'(1)) begin
					res_set      = 1'b1;
					res_status_d = lss_pkg::STAT_SINGLE;
					res_chosen_d = lss_pkg::SLOT_W'(single_q);
					win_set      = 1'b1;
					state_d      = lss_pkg::S_REPLY;
				end else if (run_q == '0) begin
					res_set      = 1'b1;
					res_status_d = lss_pkg::STAT_ZERO;
					state_d      = lss_pkg::S_REPLY;
				end else begin
					div_start = 1'b1;
					state_d   = lss_pkg::S_DIV;
				end
			end
			lss_pkg::S_DIV: begin
				if (div_done) begin
					scan_clr = 1'b1;
					state_d  = lss_pkg::S_PICK;
				end
			end
			lss_pkg::S_PICK: begin
				scan_step = 1'b1;
				if (hit) begin
					res_set      = 1'b1;
					res_status_d = lss_pkg::STAT_DRAWN;
					res_chosen_d = lss_pkg::SLOT_W'(idx_s1);
					win_set      = 1'b1;
					state_d      = lss_pkg::S_REPLY;
				end else if (cnt_q == CNT_W'(SLOTS)) begin
					state_d = lss_pkg::S_REPLY;
				end
			end
			lss_pkg::S_REPLY: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = lss_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lss_pkg::S_IDLE;
			end
		endcase
	end

	// slot state: live flags, live count, last winner
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q        <= '0;
			live_cnt_q    <= '0;
			last_winner_q <= '0;
			win_vld_q     <= 1'b0;
		end else begin
			if (do_load) begin
				live_q[slot_idx] <= 1'b1;
				if (!live_at_slot) begin
					live_cnt_q <= live_cnt_q + 1'b1;
				end
			end
			if (do_finish) begin
				live_q[slot_idx] <= 1'b0;
				if (live_at_slot) begin
					live_cnt_q <= live_cnt_q - 1'b1;
				end
			end
			if (win_set) begin
				last_winner_q <= res_chosen_d;
				win_vld_q     <= 1'b1;
			end
		end
	end

	// scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (scan_clr) begin
			cnt_q <= '0;
		end else if (scan_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// scan datapath: request capture, running sum, single live slot, picked value, result
	always_ff @(posedge clk) begin
		if (state_q == lss_pkg::S_IDLE && req_valid) begin
			req_q <= req;
		end
		if (scan_step) begin
			idx_s1 <= cnt_q[IDX_W-1:0];
		end
		if (scan_clr) begin
			run_q <= '0;
		end else if (scan_step && proc_vld && elig_s1) begin
			run_q <= run_sum;
		end
		if (state_q == lss_pkg::S_SUM && proc_vld && live_q[idx_s1]) begin
			single_q <= idx_s1;
		end
		if (state_q == lss_pkg::S_DIV && div_done) begin
			pick_q <= div_rem;
		end
		if (res_set) begin
			res_status_q <= res_status_d;
			res_chosen_q <= res_chosen_d;
		end
	end

	// reply register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.status      <= res_status_q;
			rsp_q.chosen_slot <= res_chosen_q;
			rsp_q.live_count  <= live_cnt_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- test/tb_top.sv -----
// lottery slot selector testbench: directed table plus random words against a predictor
`timescale 1ns / 1ps

module tb_top;

	// opcode that the block acknowledges without any effect
	localparam logic [lss_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
	localparam int unsigned PHASE_WORDS = 450;
	localparam int unsigned DRAIN_CYCLES = 64;

	typedef struct {
		lss_pkg::lss_req_t w;
		bit                known;
		lss_pkg::lss_rsp_t exp;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	lss_pkg::lss_req_t req = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	lss_pkg::lss_rsp_t rsp;

	// predictor state
	logic [lss_pkg::TICKETS_W-1:0] slot_tickets [lss_pkg::SLOTS_DEF];
	bit                            slot_live [lss_pkg::SLOTS_DEF];
	logic [lss_pkg::SLOT_W-1:0]    last_pick = '0;
	bit                            last_pick_valid = 1'b0;

	lss_pkg::lss_rsp_t pending_replies [$];
	stim_row_t         directed_rows [$];
	int unsigned       mismatches = 0;
	bit                tx_idles = 1'b0;
	bit                rx_idles = 1'b0;
	int unsigned       idle_pct = 0;

	lottery_slot_selector uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// hard stop if the run hangs
	initial begin
		#10_000_000;
		$display("[lottery_slot_selector] ERROR");
		$finish;
	end

	function automatic logic [lss_pkg::LIVE_W-1:0] live_total();
		logic [lss_pkg::LIVE_W-1:0] n;
		n = '0;
		for (int i = 0; i < lss_pkg::SLOTS_DEF; i++) begin
			if (slot_live[i]) begin
				n++;
			end
		end
		return n;
	endfunction

	// apply one word to the slot state and work out its reply
	function automatic lss_pkg::lss_rsp_t predict_reply(input lss_pkg::lss_req_t w);
		lss_pkg::lss_rsp_t r;
		bit                elig [lss_pkg::SLOTS_DEF];
		logic [31:0]       pool, pick, lo, hi;
		bit                found;
		r = '0;
		r.status = lss_pkg::STAT_ACK;
		if (w.opcode == lss_pkg::OP_LOAD) begin
			slot_tickets[w.slot] = w.tickets;
			slot_live[w.slot] = 1'b1;
		end else if (w.opcode == lss_pkg::OP_FINISH) begin
			slot_live[w.slot] = 1'b0;
		end else if (w.opcode == lss_pkg::OP_DRAW) begin
			if (live_total() == 0) begin
				r.status = lss_pkg::STAT_NONE;
			end else if (live_total() == 1) begin
				for (int i = 0; i < lss_pkg::SLOTS_DEF; i++) begin
					if (slot_live[i]) begin
						r.chosen_slot = lss_pkg::SLOT_W'(i);
					end
				end
				last_pick = r.chosen_slot;
				last_pick_valid = 1'b1;
				r.status = lss_pkg::STAT_SINGLE;
			end else begin
				// previous winner sits out this draw
				pool = '0;
				for (int i = 0; i < lss_pkg::SLOTS_DEF; i++) begin
					elig[i] = slot_live[i] &&
						!(last_pick_valid && last_pick == lss_pkg::SLOT_W'(i));
					if (elig[i]) begin
						pool += 32'(slot_tickets[i]);
					end
				end
				if (pool == 0) begin
					r.status = lss_pkg::STAT_ZERO;
				end else begin
					// half-open cumulative ranges in slot order
					pick = w.random_value % pool;
					lo = '0;
					found = 1'b0;
					for (int i = 0; i < lss_pkg::SLOTS_DEF; i++) begin
						if (elig[i] && !found) begin
							hi = lo + 32'(slot_tickets[i]);
							if (pick >= lo && pick < hi) begin
								r.chosen_slot = lss_pkg::SLOT_W'(i);
								found = 1'b1;
							end
							lo = hi;
						end
					end
					last_pick = r.chosen_slot;
					last_pick_valid = 1'b1;
					r.status = lss_pkg::STAT_DRAWN;
				end
			end
		end
		r.live_count = live_total();
		return r;
	endfunction

	function automatic void add_row(input logic [lss_pkg::OPCODE_W-1:0] op,
			input int unsigned slot, input logic [lss_pkg::TICKETS_W-1:0] tk,
			input logic [lss_pkg::RANDOM_W-1:0] rnd, input bit known,
			input logic [lss_pkg::STATUS_W-1:0] st, input int unsigned ch,
			input int unsigned lv);
		stim_row_t row;
		row.w.opcode = op;
		row.w.slot = lss_pkg::SLOT_W'(slot);
		row.w.tickets = tk;
		row.w.random_value = rnd;
		row.known = known;
		row.exp.status = st;
		row.exp.chosen_slot = lss_pkg::SLOT_W'(ch);
		row.exp.live_count = lss_pkg::LIVE_W'(lv);
		directed_rows.push_back(row);
	endfunction

	function automatic lss_pkg::lss_req_t random_word(input int unsigned load_pct);
		lss_pkg::lss_req_t w;
		int unsigned       r;
		w.slot = lss_pkg::SLOT_W'($urandom_range(lss_pkg::SLOTS_DEF - 1));
		w.random_value = ($urandom_range(3) == 0) ? 32'($urandom_range(3)) : $urandom;
		case ($urandom_range(3))
			0: w.tickets = 16'($urandom_range(15));
			1: w.tickets = 16'($urandom_range(255));
			2: w.tickets = 16'hFFFF - 16'($urandom_range(3));
			default: w.tickets = 16'($urandom);
		endcase
		r = $urandom_range(99);
		if (r < load_pct) begin
			w.opcode = lss_pkg::OP_LOAD;
		end else if (r < 50) begin
			w.opcode = lss_pkg::OP_FINISH;
		end else if (r < 95) begin
			w.opcode = lss_pkg::OP_DRAW;
		end else begin
			w.opcode = OP_UNUSED;
		end
		return w;
	endfunction

	// offer one word, hold it until taken, then record its reply
	task automatic send_word(input lss_pkg::lss_req_t w, input bit known,
			input lss_pkg::lss_rsp_t typed);
		lss_pkg::lss_rsp_t predicted;
		if (tx_idles) begin
			while ($urandom_range(99) < idle_pct) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
		predicted = predict_reply(w);
		pending_replies.push_back(known ? typed : predicted);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_replies.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// reply checker and receiver stall
	always @(posedge clk) begin
		lss_pkg::lss_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t reply word with nothing expected: status %0d slot %0d live %0d",
						$realtime, rsp.status, rsp.chosen_slot, rsp.live_count);
				end
			end else begin
				want = pending_replies.pop_front();
				if (rsp.status !== want.status || rsp.chosen_slot !== want.chosen_slot ||
						rsp.live_count !== want.live_count) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t reply mismatch: expected status %0d slot %0d live %0d,",
							$realtime, want.status, want.chosen_slot, want.live_count,
							" got status %0d slot %0d live %0d",
							rsp.status, rsp.chosen_slot, rsp.live_count);
					end
				end
			end
		end
		rsp_stall <= rx_idles ? ($urandom_range(99) < idle_pct) : 1'b0;
	end

	initial begin
		lss_pkg::lss_req_t w;
		lss_pkg::lss_rsp_t none;
		int unsigned       counted;
		none = '0;
		for (int i = 0; i < lss_pkg::SLOTS_DEF; i++) begin
			slot_tickets[i] = '0;
			slot_live[i] = 1'b0;
		end

		// empty pool, finish of a dead slot, unused opcode, single live slot, drawn winners, zero-ticket pool
		add_row(lss_pkg::OP_DRAW,   0, 16'h0000, 32'h00000000, 1, lss_pkg::STAT_NONE,   0, 0);
		add_row(lss_pkg::OP_FINISH, 0, 16'h0000, 32'h00000000, 1, lss_pkg::STAT_ACK,    0, 0);
		add_row(OP_UNUSED,          5, 16'hFFFF, 32'hFFFFFFFF, 1, lss_pkg::STAT_ACK,    0, 0);
		add_row(lss_pkg::OP_LOAD,   7, 16'h0000, 32'h00000000, 1, lss_pkg::STAT_ACK,    0, 1);
		add_row(lss_pkg::OP_DRAW,   0, 16'h0000, 32'h00000000, 1, lss_pkg::STAT_SINGLE, 7, 1);
		add_row(lss_pkg::OP_DRAW,   0, 16'h0000, 32'hFFFFFFFF, 1, lss_pkg::STAT_SINGLE, 7, 1);
		add_row(lss_pkg::OP_LOAD,   0, 16'hFFFF, 32'h00000000, 1, lss_pkg::STAT_ACK,    0, 2);
		add_row(lss_pkg::OP_DRAW,   0, 16'h0000, 32'h00000000, 1, lss_pkg::STAT_DRAWN,  0, 2);
		add_row(lss_pkg::OP_DRAW,   0, 16'h0000, 32'hFFFFFFFF, 1, lss_pkg::STAT_ZERO,   0, 2);
		add_row(lss_pkg::OP_LOAD,   3, 16'h0001, 32'h00000000, 1, lss_pkg::STAT_ACK,    0, 3);
		add_row(lss_pkg::OP_DRAW,   0, 16'h0000, 32'hFFFFFFFF, 1, lss_pkg::STAT_DRAWN,  3, 3);
		// finished last winner
		add_row(lss_pkg::OP_FINISH, 3, 16'h0000, 32'h00000000, 1, lss_pkg::STAT_ACK,    0, 2);
		add_row(lss_pkg::OP_DRAW,   0, 16'h0000, 32'h00000000, 0, lss_pkg::STAT_ACK,    0, 0);
		// fill every slot
		add_row(lss_pkg::OP_LOAD,   1, 16'hAAAA, 32'h00000000, 0, lss_pkg::STAT_ACK,    0, 0);
		add_row(lss_pkg::OP_LOAD,   2, 16'h5555, 32'h00000000, 0, lss_pkg::STAT_ACK,    0, 0);
		add_row(lss_pkg::OP_LOAD,   4, 16'h8000, 32'h00000000, 0, lss_pkg::STAT_ACK,    0, 0);
		add_row(lss_pkg::OP_LOAD,   5, 16'h7FFF, 32'h00000000, 0, lss_pkg::STAT_ACK,    0, 0);
		add_row(lss_pkg::OP_LOAD,   6, 16'h0001, 32'h00000000, 0, lss_pkg::STAT_ACK,    0, 0);
		add_row(lss_pkg::OP_LOAD,   3, 16'h1234, 32'h00000000, 1, lss_pkg::STAT_ACK,    0, 8);
		add_row(lss_pkg::OP_DRAW,   0, 16'h0000, 32'hAAAAAAAA, 0, lss_pkg::STAT_ACK,    0, 0);
		add_row(lss_pkg::OP_DRAW,   0, 16'h0000, 32'h55555555, 0, lss_pkg::STAT_ACK,    0, 0);
		add_row(lss_pkg::OP_DRAW,   0, 16'h0000, 32'hFFFFFFFF, 0, lss_pkg::STAT_ACK,    0, 0);
		add_row(lss_pkg::OP_DRAW,   0, 16'h0000, 32'h00000000, 0, lss_pkg::STAT_ACK,    0, 0);
		add_row(lss_pkg::OP_FINISH, 7, 16'h0000, 32'h00000000, 0, lss_pkg::STAT_ACK,    0, 0);
		add_row(OP_UNUSED,          0, 16'h0000, 32'h00000000, 0, lss_pkg::STAT_ACK,    0, 0);

		// reset
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling
		foreach (directed_rows[i]) begin
			send_word(directed_rows[i].w, directed_rows[i].known, directed_rows[i].exp);
		end

		// random phases: none, sender idles, receiver stalls, both
		for (int phase = 0; phase < 4; phase++) begin
			wait_drained();
			tx_idles = (phase == 1 || phase == 3);
			rx_idles = (phase == 2 || phase == 3);
			idle_pct = (phase == 3) ? 27 : 73;
			counted = 0;
			while (counted < PHASE_WORDS) begin
				w = random_word((phase == 1) ? 20 : 30);
				send_word(w, 1'b0, none);
				if (w.opcode != OP_UNUSED) begin
					counted++;
				end
			end
		end

		// drain and let the block settle
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("[lottery_slot_selector] OK");
		end else begin
			$display("[lottery_slot_selector] ERROR");
		end
		$finish;
	end

endmodule
